### rtl/core/sliding_window_median_defines.svh
// ----------------------------------------------------------------------------
// sliding window median assertion macros
// shared property forms for the running median filter checks
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swm check failed");

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swm check failed");

`endif

### rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// types and constants of the sliding window median filter
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int unsigned MAX_WINDOW  = 16;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_RESET   = 3;
  localparam int unsigned IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_WINDOW + 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS:0] median_doubled;
    logic                        end_of_sequence;
  } out_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic [IDX_W-1:0]              age;
  } cell_data_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          accept;
    logic                          full;
    logic [IDX_W-1:0]              age_del;
    logic [CNT_W-1:0]              fill;
    logic [CNT_W-1:0]              n_keep;
    logic [CNT_W-1:0]              rm_idx;
  } cell_ctrl_t;

endpackage

### rtl/core/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// one slot of the sorted window: drops the oldest entry and inserts the new
// sample in order, trading entries with its neighbors
// ----------------------------------------------------------------------------
module swm_cell (
  input  logic                 clk_i,
  input  logic [swm_pkg::IDX_W-1:0] idx_i,
  input  swm_pkg::cell_ctrl_t  ctrl_i,
  input  swm_pkg::cell_data_t  right_a_i,
  input  swm_pkg::cell_data_t  left_b_i,
  input  logic                 left_le_i,
  output swm_pkg::cell_data_t  a_o,
  output swm_pkg::cell_data_t  b_o,
  output logic                 le_o,
  output logic                 del_o
);

  swm_pkg::cell_data_t data_q, data_d, pick;
  logic [swm_pkg::CNT_W-1:0] idx_c;
  logic keep, b_valid;

  assign idx_c = swm_pkg::CNT_W'(idx_i);
  assign a_o   = data_q;
  assign del_o = ctrl_i.full && (idx_c < ctrl_i.fill) && (data_q.age == ctrl_i.age_del);

  // window after removal of the oldest entry
  assign keep    = idx_c < ctrl_i.rm_idx;
  assign b_o     = keep ? data_q : right_a_i;
  assign b_valid = idx_c < ctrl_i.n_keep;
  assign le_o    = b_valid && (b_o.val <= ctrl_i.sample);

  always_comb begin
    pick = le_o ? b_o : left_b_i;
    if (!le_o && left_le_i) begin
      data_d.val = ctrl_i.sample;
      data_d.age = '0;
    end else begin
      data_d.val = pick.val;
      data_d.age = pick.age + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      data_q <= data_d;
    end
  end

endmodule

### rtl/core/swm_median.sv
// ----------------------------------------------------------------------------
// swm_median
// picks the middle entries of the sorted window and holds the result word
// ----------------------------------------------------------------------------
module swm_median (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  swm_pkg::cell_data_t       cells_i [swm_pkg::MAX_WINDOW],
  input  logic [swm_pkg::CNT_W-1:0] win_i,
  input  logic                      pend_i,
  input  logic                      pend_last_i,
  input  logic                      stall_i,
  output logic                      valid_o,
  output swm_pkg::out_word_t        word_o
);

  localparam int unsigned S = swm_pkg::SAMPLE_BITS;

  logic [swm_pkg::CNT_W-1:0] hi_idx, lo_idx;
  logic signed [S-1:0] lo_v, hi_v;
  logic valid_q, load;
  swm_pkg::out_word_t word_q;

  assign hi_idx = win_i >> 1;
  assign lo_idx = win_i[0] ? hi_idx : hi_idx - 1'b1;

  always_comb begin
    lo_v = '0;
    hi_v = '0;
    for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
      if (swm_pkg::CNT_W'(i) == lo_idx) lo_v = lo_v | cells_i[i].val;
      if (swm_pkg::CNT_W'(i) == hi_idx) hi_v = hi_v | cells_i[i].val;
    end
  end

  assign load = pend_i && !(valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q.median_doubled  <= {lo_v[S-1], lo_v} + {hi_v[S-1], hi_v};
      word_q.end_of_sequence <= pend_last_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### rtl/core/sliding_window_median.sv
// ----------------------------------------------------------------------------
// sliding_window_median
// running median over the last window_size samples, kept in a sorted row of
// cells; each word gives twice the median once the window is full
// ----------------------------------------------------------------------------
// result path: an accepted sample is stored in the cell row and pend_q; swm_median then registers the word
// throughput: one sample per cycle while in_stall_o is low, the cell row drops and inserts in one step
// reset: window_size 3, window empty, no pending result; cell contents unreset
// a window_size write also empties the window
module sliding_window_median (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  swm_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output swm_pkg::out_word_t            out_word_o
);

  `include "sliding_window_median_defines.svh"

  localparam int unsigned N = swm_pkg::MAX_WINDOW;

  logic [swm_pkg::CFG_W-1:0] cfg_q;
  logic [swm_pkg::CNT_W-1:0] fill_q, fill_d, win, rm_enc;
  logic pend_q, pend_d, pend_last_q, pend_last_d;
  logic accept, full, produces;
  logic [N-1:0] del_vec, le_vec;
  swm_pkg::cell_ctrl_t ctrl;
  swm_pkg::cell_data_t a_vec [N];
  swm_pkg::cell_data_t b_vec [N];

  always_comb begin
    if (cfg_q == '0) begin
      win = swm_pkg::CNT_W'(1);
    end else if (32'(cfg_q) > 32'(N)) begin
      win = swm_pkg::CNT_W'(N);
    end else begin
      win = swm_pkg::CNT_W'(cfg_q);
    end
  end

  assign full       = fill_q == win;
  assign in_stall_o = pend_q && out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign produces   = full || ((fill_q + 1'b1) == win);

  always_comb begin
    rm_enc = '0;
    for (int i = 0; i < N; i++) begin
      if (del_vec[i]) rm_enc = rm_enc | swm_pkg::CNT_W'(i);
    end
  end

  always_comb begin
    ctrl.sample  = in_word_i.sample;
    ctrl.accept  = accept;
    ctrl.full    = full;
    ctrl.age_del = swm_pkg::IDX_W'(win - 1'b1);
    ctrl.fill    = fill_q;
    ctrl.n_keep  = full ? win - 1'b1 : fill_q;
    ctrl.rm_idx  = full ? rm_enc : swm_pkg::CNT_W'(N);
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    swm_pkg::cell_data_t right_a, left_b;
    logic left_le;
    if (g == N - 1) begin : g_last
      assign right_a = '0;
    end else begin : g_mid
      assign right_a = a_vec[g+1];
    end
    if (g == 0) begin : g_first
      assign left_b  = '0;
      assign left_le = 1'b1;
    end else begin : g_rest
      assign left_b  = b_vec[g-1];
      assign left_le = le_vec[g-1];
    end
    swm_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (swm_pkg::IDX_W'(g)),
      .ctrl_i    (ctrl),
      .right_a_i (right_a),
      .left_b_i  (left_b),
      .left_le_i (left_le),
      .a_o       (a_vec[g]),
      .b_o       (b_vec[g]),
      .le_o      (le_vec[g]),
      .del_o     (del_vec[g])
    );
  end

  always_comb begin
    fill_d      = fill_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    if (cfg_we_i) begin
      fill_d = '0;
    end else if (accept) begin
      if (in_word_i.last_sample) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill_q + 1'b1;
      end
    end
    if (accept) begin
      pend_d      = produces;
      pend_last_d = in_word_i.last_sample;
    end else if (pend_q && !(out_valid_o && out_stall_i)) begin
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= swm_pkg::CFG_W'(swm_pkg::CFG_RESET);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

  swm_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cells_i     (a_vec),
    .win_i       (win),
    .pend_i      (pend_q),
    .pend_last_i (pend_last_q),
    .stall_i     (out_stall_i),
    .valid_o     (out_valid_o),
    .word_o      (out_word_o)
  );

  `SWM_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_q <= win)
  `SWM_ASSERT_IMPLY(a_del_onehot, full, $onehot(del_vec))
  `SWM_ASSERT_NEXT(a_pend_held, pend_q && out_valid_o && out_stall_i, pend_q)
  `SWM_ASSERT_NEXT(a_result_queued, accept && produces, pend_q)

endmodule

### test/tb_sliding_window_median.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_median
// self-checking bench for the running median filter: a scoreboard keeps its
// own sorted window and ring, predicts twice the median of every full window
// and checks each output word in order, across window sizes and idle patterns
// ----------------------------------------------------------------------------
module tb_sliding_window_median;

  localparam int WATCHDOG_LIMIT = 4000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [swm_pkg::CFG_W-1:0]       cfg_wdata = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  swm_pkg::in_word_t               in_word = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  swm_pkg::out_word_t              out_word;

  int                              src_idle_pct = 0;
  int                              sink_stall_pct = 0;
  int                              fail_count = 0;
  int                              idle_cycles = 0;

  // scoreboard copy of the filter state
  logic [swm_pkg::CFG_W-1:0]              win_cfg = swm_pkg::CFG_W'(swm_pkg::CFG_RESET);
  logic signed [swm_pkg::SAMPLE_BITS-1:0] age_q [swm_pkg::MAX_WINDOW];
  logic signed [swm_pkg::SAMPLE_BITS-1:0] rank_q [swm_pkg::MAX_WINDOW];
  int                                     held = 0;
  int                                     oldest = 0;
  swm_pkg::out_word_t                     median_q [$];

  sliding_window_median i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #6 clk = ~clk;

  function automatic int window_len(logic [swm_pkg::CFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
    return int'(w);
  endfunction

  function automatic void rank_insert(int cnt, logic signed [swm_pkg::SAMPLE_BITS-1:0] v);
    int i;
    i = cnt;
    while (i > 0 && rank_q[i-1] > v) begin
      rank_q[i] = rank_q[i-1];
      i--;
    end
    rank_q[i] = v;
  endfunction

  function automatic void predict_median(swm_pkg::in_word_t w);
    int n;
    int i;
    int m2;
    logic signed [swm_pkg::SAMPLE_BITS-1:0] old;
    swm_pkg::out_word_t r;
    n = window_len(win_cfg);
    if (held > n) begin
      held = 0;
      oldest = 0;
    end
    if (oldest >= n) oldest = 0;
    if (held < n) begin
      age_q[held] = w.sample;
      rank_insert(held, w.sample);
      held++;
    end else begin
      old = age_q[oldest];
      i = 0;
      while (i < n && rank_q[i] != old) i++;
      if (i < n) begin
        for (; i + 1 < n; i++) rank_q[i] = rank_q[i+1];
      end
      rank_insert(n - 1, w.sample);
      age_q[oldest] = w.sample;
      oldest = (oldest + 1 >= n) ? 0 : oldest + 1;
    end
    if (held == n) begin
      if (n % 2 == 0) m2 = int'(rank_q[n/2-1]) + int'(rank_q[n/2]);
      else m2 = 2 * int'(rank_q[n/2]);
      r.median_doubled = m2[swm_pkg::SAMPLE_BITS:0];
      r.end_of_sequence = w.last_sample;
      median_q.insert(median_q.size(), r);
    end
    if (w.last_sample) begin
      held = 0;
      oldest = 0;
    end
  endfunction

  // checks output words, then takes in config writes and accepted samples
  always @(posedge clk) begin
    swm_pkg::out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (median_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected word: median %0d eos %0b",
                     out_word.median_doubled, out_word.end_of_sequence);
          fail_count++;
        end else begin
          want = median_q[0];
          median_q.delete(0);
          if (out_word.median_doubled !== want.median_doubled ||
              out_word.end_of_sequence !== want.end_of_sequence) begin
            if (fail_count < 10)
              $display("word mismatch: expected median %0d eos %0b, got median %0d eos %0b",
                       want.median_doubled, want.end_of_sequence,
                       out_word.median_doubled, out_word.end_of_sequence);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        win_cfg = cfg_wdata;
        held = 0;
        oldest = 0;
      end
      if (in_valid && !in_stall) predict_median(in_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sliding_window_median regression: fail");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  task automatic send_word(logic signed [swm_pkg::SAMPLE_BITS-1:0] s, logic last);
    swm_pkg::in_word_t w;
    w.sample = s;
    w.last_sample = last;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic hold_until_drained(int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_window(logic [swm_pkg::CFG_W-1:0] w);
    hold_until_drained(4);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [swm_pkg::SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return swm_pkg::SAMPLE_BITS'($urandom_range(0, 6)) - 16'sd3;
      default: return swm_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [swm_pkg::CFG_W-1:0] rand_window();
    if ($urandom_range(0, 3) == 0) return swm_pkg::CFG_W'($urandom_range(0, 31));
    return swm_pkg::CFG_W'($urandom_range(1, 5));
  endfunction

  task automatic send_sequence(int len);
    for (int k = 0; k < len; k++) send_word(rand_sample(), k == len - 1);
  endtask

  // reset window of three, extremes, end of sequence early and on a full window
  task automatic test_default_window();
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(-16'sd1, 1'b0);
    send_word(16'sd1, 1'b1);
    send_word(16'sd5, 1'b0);
    send_word(16'sd6, 1'b1);
    send_word(16'sd9, 1'b1);
    send_word(16'sh5555, 1'b0);
    send_word(16'shaaaa, 1'b0);
    send_word(16'shaaaa, 1'b1);
    set_window(5'd2);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh7fff, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7fff, 1'b1);
  endtask

  // zero, saturating and edge window sizes
  task automatic test_window_sizes();
    logic [swm_pkg::CFG_W-1:0] sizes [8] = '{5'd0, 5'd1, 5'd2, 5'd15, 5'd16, 5'd17, 5'd31, 5'd3};
    src_idle_pct = 31;
    sink_stall_pct = 31;
    foreach (sizes[k]) begin
      set_window(sizes[k]);
      send_sequence(window_len(sizes[k]) + 3);
      send_sequence($urandom_range(1, window_len(sizes[k])));
      send_sequence(window_len(sizes[k]) + 1);
    end
  endtask

  task automatic test_random_traffic();
    int idle_pct [4] = '{0, 59, 0, 31};
    int stall_pct [4] = '{0, 0, 59, 31};
    int count;
    int n;
    int len;
    bit paused;
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = idle_pct[p];
      sink_stall_pct = stall_pct[p];
      set_window(rand_window());
      count = 0;
      paused = 1'b0;
      while (count < 260) begin
        if ($urandom_range(0, 9) == 0) set_window(rand_window());
        n = window_len(win_cfg);
        case ($urandom_range(0, 9))
          8: len = $urandom_range(1, n);
          9: len = $urandom_range(1, 2 * n);
          default: len = n + $urandom_range(0, 24);
        endcase
        if (count > 130 && !paused) begin
          hold_until_drained(0);
          paused = 1'b1;
        end
        send_sequence(len);
        count += len;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_default_window();
    test_window_sizes();
    test_random_traffic();
    hold_until_drained(8);
    if (fail_count == 0 && median_q.size() == 0) begin
      $display("sliding_window_median regression: pass");
    end else begin
      $display("sliding_window_median regression: fail");
    end
    $finish;
  end

endmodule

### sliding_window_median.f
+incdir+rtl/core
rtl/core/swm_pkg.sv
rtl/core/swm_cell.sv
rtl/core/swm_median.sv
rtl/core/sliding_window_median.sv
test/tb_sliding_window_median.sv
